### hdl/swaf_pkg.sv
// ----------------------------------------------------------------------------
// swaf_pkg
// Shared types and constants for the sliding window anagram finder.
// ----------------------------------------------------------------------------
package swaf_pkg;

  localparam int ALPHABET_SIZE   = 26;
  localparam int MAX_PATTERN_LEN = 64;
  localparam int MAX_TEXT_LEN    = 1048576;

  localparam int OPCODE_W = 2;
  localparam int LETTER_W = 5;
  localparam int INDEX_W  = 20;
  // Counts reach MAX_PATTERN_LEN itself, ring pointers stay below it.
  localparam int COUNT_W  = $clog2(MAX_PATTERN_LEN + 1);
  localparam int PTR_W    = $clog2(MAX_PATTERN_LEN);
  // Text position saturates at MAX_TEXT_LEN.
  localparam int POS_W    = $clog2(MAX_TEXT_LEN + 1);
  localparam int START_W  = POS_W + 1;
  localparam int INDEX_MAX_RAW = (MAX_TEXT_LEN - 1 < (1 << INDEX_W) - 1) ?
                                 MAX_TEXT_LEN - 1 : (1 << INDEX_W) - 1;
  localparam logic [START_W-1:0] START_MAX = START_W'(INDEX_MAX_RAW);

  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PATTERN = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TEXT    = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_PATTERN,
    CMD_TEXT
  } cmd_kind_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [LETTER_W-1:0] letter;
  } req_t;

  typedef struct packed {
    logic               is_match;
    logic [INDEX_W-1:0] window_start;
    logic               index_overflow;
  } rsp_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [LETTER_W-1:0] letter;
  } cmd_t;

endpackage

### hdl/swaf_front.sv
// ----------------------------------------------------------------------------
// swaf_front
// Takes requests, drops those that do nothing and hands commands onward.
// ----------------------------------------------------------------------------
module swaf_front import swaf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  logic accept;
  logic keep;
  cmd_t cmd_next;

  assign req_ready = !cmd_valid || cmd_ready;
  assign accept    = req_valid && req_ready;

  // Unused opcode, or a letter outside the alphabet, is dropped here.
  always_comb begin
    keep            = 1'b0;
    cmd_next.kind   = CMD_CLEAR;
    cmd_next.letter = req_data.letter;
    unique case (req_data.opcode)
      OP_CLEAR: begin
        keep = 1'b1;
      end
      OP_PATTERN: begin
        keep          = req_data.letter < LETTER_W'(ALPHABET_SIZE);
        cmd_next.kind = CMD_PATTERN;
      end
      OP_TEXT: begin
        keep          = req_data.letter < LETTER_W'(ALPHABET_SIZE);
        cmd_next.kind = CMD_TEXT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= keep;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

### hdl/swaf_queue.sv
// ----------------------------------------------------------------------------
// swaf_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module swaf_queue import swaf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### hdl/swaf_back.sv
// ----------------------------------------------------------------------------
// swaf_back
// Executes commands: histograms, window ring, position and result register.
// ----------------------------------------------------------------------------
module swaf_back import swaf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  logic [COUNT_W-1:0]  pat_counts      [ALPHABET_SIZE];
  logic [COUNT_W-1:0]  win_counts      [ALPHABET_SIZE];
  logic [COUNT_W-1:0]  pat_counts_next [ALPHABET_SIZE];
  logic [COUNT_W-1:0]  win_counts_next [ALPHABET_SIZE];
  logic [LETTER_W-1:0] ring [MAX_PATTERN_LEN];

  logic [COUNT_W-1:0]  pat_len, pat_len_next;
  logic [COUNT_W-1:0]  fill, fill_next;
  logic [PTR_W-1:0]    ptr, ptr_next;
  logic [POS_W-1:0]    text_pos, text_pos_next;
  logic                overflow, overflow_next;
  logic [LETTER_W-1:0] oldest;

  logic               go;
  logic               do_clear;
  logic               do_pattern;
  logic               do_text;
  logic               full;
  logic               give_result;
  logic [COUNT_W-1:0] ptr_inc;
  logic [COUNT_W-1:0] fill_inc;
  logic [START_W-1:0] start_raw;
  logic [START_W-1:0] start_sum;
  logic [START_W-1:0] start_len;
  logic               match;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign go        = cmd_valid && cmd_ready;

  assign do_clear   = go && cmd.kind == CMD_CLEAR;
  assign do_pattern = go && cmd.kind == CMD_PATTERN && text_pos == '0 &&
                      pat_len < COUNT_W'(MAX_PATTERN_LEN);
  assign do_text    = go && cmd.kind == CMD_TEXT && pat_len != '0;

  assign full     = fill == pat_len;
  assign fill_inc = fill + COUNT_W'(1);
  assign ptr_inc  = COUNT_W'(ptr) + COUNT_W'(1);

  always_comb begin
    pat_len_next  = pat_len;
    fill_next     = fill;
    ptr_next      = ptr;
    text_pos_next = text_pos;
    overflow_next = overflow;
    give_result   = 1'b0;
    if (do_clear) begin
      pat_len_next  = '0;
      fill_next     = '0;
      ptr_next      = '0;
      text_pos_next = '0;
      overflow_next = 1'b0;
    end else if (do_pattern) begin
      pat_len_next = pat_len + COUNT_W'(1);
    end else if (do_text) begin
      if (text_pos >= POS_W'(MAX_TEXT_LEN)) begin
        overflow_next = 1'b1;
      end else begin
        text_pos_next = text_pos + POS_W'(1);
      end
      if (!full) begin
        fill_next = fill_inc;
      end
      ptr_next    = (ptr_inc == pat_len) ? '0 : ptr_inc[PTR_W-1:0];
      give_result = full || fill_inc == pat_len;
    end
  end

  // Each letter lane moves on its own; at most two lanes change per text letter.
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      pat_counts_next[i] = pat_counts[i];
      win_counts_next[i] = win_counts[i];
      if (do_clear) begin
        pat_counts_next[i] = '0;
        win_counts_next[i] = '0;
      end else begin
        if (do_pattern && cmd.letter == LETTER_W'(i)) begin
          pat_counts_next[i] = pat_counts[i] + COUNT_W'(1);
        end
        if (do_text) begin
          win_counts_next[i] = win_counts[i]
                             + COUNT_W'(cmd.letter == LETTER_W'(i))
                             - COUNT_W'(full && oldest == LETTER_W'(i));
        end
      end
      if (win_counts_next[i] != pat_counts_next[i]) begin
        match = 1'b0;
      end
    end
  end

  assign start_sum = START_W'(text_pos) + START_W'(1);
  assign start_len = START_W'(pat_len);
  assign start_raw = (start_sum >= start_len) ? start_sum - start_len : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len  <= '0;
      fill     <= '0;
      ptr      <= '0;
      text_pos <= '0;
      overflow <= 1'b0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        pat_counts[i] <= '0;
        win_counts[i] <= '0;
      end
    end else begin
      pat_len    <= pat_len_next;
      fill       <= fill_next;
      ptr        <= ptr_next;
      text_pos   <= text_pos_next;
      overflow   <= overflow_next;
      pat_counts <= pat_counts_next;
      win_counts <= win_counts_next;
    end
  end

  // Window ring; oldest always holds the entry at ptr, with write bypass
  // for a one-letter window.
  always_ff @(posedge clk) begin
    if (do_text) begin
      ring[ptr] <= cmd.letter;
    end
    if (do_text && ptr_next == ptr) begin
      oldest <= cmd.letter;
    end else begin
      oldest <= ring[ptr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go && give_result) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && give_result) begin
      rsp_data.is_match       <= match;
      rsp_data.window_start   <= (start_raw > START_MAX) ? START_MAX[INDEX_W-1:0]
                                                         : start_raw[INDEX_W-1:0];
      rsp_data.index_overflow <= overflow_next;
    end
  end

endmodule

### hdl/sliding_window_anagram_finder.sv
// rsp_valid is registered after the front register and a queue entry.
// Throughput: one request per cycle; the front register, the two-entry queue
// and the back end each stall independently on back-pressure.
// Reset (rst, synchronous) clears histograms, lengths, position and flags;
// the window ring is not cleared, only entries written since are read.
// ----------------------------------------------------------------------------
// sliding_window_anagram_finder
// Reports, per text letter once the window is full, whether the window is an
// anagram of the loaded pattern, with the window's start index.
// ----------------------------------------------------------------------------
module sliding_window_anagram_finder import swaf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic back_valid;
  logic back_ready;
  cmd_t back_cmd;

  swaf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  swaf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  swaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule
